// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the color conversion rtl
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// next-cycle implication, held off while reset is asserted
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ===== rtl/core/hsv2rgb_pkg.sv =====
// shared types, constants and helpers of the hsv to rgb converter
// no dependencies
package hsv2rgb_pkg;

  localparam int HUE_W       = 16;
  localparam int SAT_W       = 11;
  localparam int MAG_W       = SAT_W - 1;
  localparam int CHAN_W      = 8;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // hue is kept in 1/16 degree
  localparam int HUE_SECTOR  = 960;
  localparam int HUE_TURN    = 6 * HUE_SECTOR;
  localparam int HUE_BIAS    = 6 * HUE_TURN;   // makes every hue positive
  localparam int HU_W        = 17;
  localparam int ST_W        = 7;
  localparam int ST_MAX      = 70;
  localparam int FX_W        = 10;

  localparam int DIV15_MUL   = 4369;           // 65535 / 15
  localparam int DIV6_MUL    = 43;             // ~256 / 6, good below 128

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t         sector;
    logic [FX_W-1:0] fx;
  } hue_split_t;

  // advance enables and valid bits of the first three stages
  typedef struct packed {
    logic [2:0] adv;
    logic [2:0] full;
  } pipe_ctrl_t;

  // floor(u / 15), exact over the whole 12-bit range of u
  function automatic logic [8:0] div15(input logic [11:0] u);
    logic [25:0] p;
    p = 26'(13'(u) + 13'd1) * 26'(DIV15_MUL);
    return p[24:16];
  endfunction

endpackage

// ===== rtl/core/hsv2rgb_hue_split.sv =====
// hue path: modulo one turn, sixty degree sector and in-sector fraction
// three register stages; depends on hsv2rgb_pkg and assert_macros.svh
module hsv2rgb_hue_split (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  hsv2rgb_pkg::pipe_ctrl_t               ctrl_i,
  input  logic signed [hsv2rgb_pkg::HUE_W-1:0]  hue_i,
  output hsv2rgb_pkg::hue_split_t               hs_o
);
  import hsv2rgb_pkg::*;
  `include "assert_macros.svh"

  logic [HU_W-1:0]  hu_r, hu_nxt;
  logic [HU_W-1:0]  hu1_r;
  logic [ST_W-1:0]  st_r, st_nxt;
  hue_split_t       hs_r, hs_nxt;

  logic [HU_W-1:0]  rem_full;
  logic [12:0]      p6;
  logic [ST_W-1:0]  sec_full;
  logic [FX_W-1:0]  rem;
  logic [8:0]       q15;

  // biased hue is always positive, same residue modulo one turn
  assign hu_nxt = HU_W'(hue_i) + HU_W'(HUE_BIAS);

  // floor(hu / 960) = floor(floor(hu / 64) / 15)
  assign q15    = div15(12'(hu_r[HU_W-1:6]));
  assign st_nxt = q15[ST_W-1:0];

  always_comb begin
    rem_full = hu1_r - HU_W'(st_r) * HU_W'(HUE_SECTOR);
    rem      = rem_full[FX_W-1:0];
    p6       = 13'(st_r) * 13'(DIV6_MUL);
    sec_full = st_r - ST_W'(6) * ST_W'(p6[12:8]);
    hs_nxt.sector = sector_t'(sec_full[2:0]);
    hs_nxt.fx     = sec_full[0] ? (FX_W'(HUE_SECTOR) - rem) : rem;
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.adv[0]) begin
      hu_r <= hu_nxt;
    end
    if (ctrl_i.adv[1]) begin
      st_r  <= st_nxt;
      hu1_r <= hu_r;
    end
    if (ctrl_i.adv[2]) begin
      hs_r <= hs_nxt;
    end
  end

  assign hs_o = hs_r;

  `ASSERT_IMPL(a_st_range, clk, rst_n, ctrl_i.full[1], st_r <= ST_W'(ST_MAX))
  `ASSERT_IMPL(a_fx_range, clk, rst_n, ctrl_i.full[2], hs_r.fx <= FX_W'(HUE_SECTOR))

endmodule

// ===== rtl/core/hsv_to_rgb_convert_unit.sv =====
// top level of the hsv to 8-bit rgb converter, six-stage pipeline
// depends on hsv2rgb_pkg, hsv2rgb_hue_split and assert_macros.svh
//
//  channel | dir | word                                    | handshake
//  --------+-----+-----------------------------------------+-------------------
//  in_     | in  | hue, saturation, brightness (40 bits)   | tvalid / tready
//  out_    | out | red, green, blue (24 bits)              | tvalid / tready
//
// one word per clock sustained while out_tready stays high; out_tvalid rises once
// the accepted word has passed the six register stages (clamp, chroma products, color
// scaling, sector product, sum and shift, divide by 15 and channel order)
// rst_n is synchronous and clears only the stage valid bits
// each stage advances when it is empty or the stage after it advances, so a
// stall on out_tready holds everything in place and bubbles still close up
module hsv_to_rgb_convert_unit #(
  parameter int FRAC_BITS  = 8,
  parameter int COLOR_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // hue[15:0] signed, saturation[26:16] signed, brightness[37:27] signed, zeros
  input  logic [hsv2rgb_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // red[7:0], green[15:8], blue[23:16]
  output logic [hsv2rgb_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import hsv2rgb_pkg::*;
  `include "assert_macros.svh"

  localparam int NSTG = 6;
  // bits of a clamped saturation or value
  localparam int VW   = (FRAC_BITS < MAG_W) ? FRAC_BITS + 1 : MAG_W;
  localparam int CW   = COLOR_BITS;
  localparam int AW   = VW + FRAC_BITS + 1;          // v * (one - s)
  localparam int BW   = 2 * VW;                      // v * s
  localparam int PW   = BW + CW + FX_W;              // chroma * fx * cmax
  localparam int EW   = CW + VW + FRAC_BITS + 11;    // x numerator
  localparam int TX_W = 12;
  localparam int TX_CAP = 3839;                      // last value below 256 * 15

  localparam logic [31:0]          ONE_32 = 32'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS:0]   ONE_U  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CW-1:0]        CMAX   = '1;
  localparam logic [63:0]          HALF_V = 64'(1) << (FRAC_BITS - 1);
  localparam logic [63:0]          HALF_M = 64'(1) << (2 * FRAC_BITS - 1);
  localparam logic [63:0]          BIAS_X = 64'(480) << (2 * FRAC_BITS);

  // clamp a signed fixed point fraction to [0, one]
  function automatic logic [VW-1:0] clamp_unit(input logic [SAT_W-1:0] x);
    logic [MAG_W-1:0] mag;
    mag = x[MAG_W-1:0];
    if (x[SAT_W-1]) begin
      return '0;
    end else if (32'(mag) > ONE_32) begin
      return ONE_32[VW-1:0];
    end else begin
      return mag[VW-1:0];
    end
  endfunction

  // saturate a channel code to 8 bits
  function automatic logic [CHAN_W-1:0] sat8(input logic [63:0] x);
    return (|x[63:CHAN_W]) ? {CHAN_W{1'b1}} : x[CHAN_W-1:0];
  endfunction

  // stage control
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;
  pipe_ctrl_t      hue_ctrl;

  // input unpacking
  logic signed [HUE_W-1:0] hue;
  logic [SAT_W-1:0]        saturation;
  logic [SAT_W-1:0]        brightness;

  // stage 0: clamped s and v
  logic [VW-1:0]        s_r, v_r;
  // stage 1: chroma products
  logic [FRAC_BITS:0]   oms;
  logic [AW-1:0]        a_r, a_nxt;
  logic [BW-1:0]        b_r, b_nxt;
  logic [VW-1:0]        v1_r;
  // stage 2: scaled by the color range
  logic [AW+CW-1:0]     acm2_r;
  logic [BW+CW-1:0]     bcm2_r;
  logic [VW+CW-1:0]     vcm2_r;
  hue_split_t           hs;
  // stage 3: secondary product, rounded primary and floor channels
  logic [PW-1:0]        px3_r, px_nxt;
  logic [AW+CW-1:0]     acm3_r;
  logic [VW+CW:0]       vsum;
  logic [AW+CW:0]       msum;
  logic [CHAN_W-1:0]    qv3_r, qv_nxt, qm3_r, qm_nxt;
  sector_t              sec3_r;
  // stage 4: x code times 15
  logic [EW-1:0]        ex, txw;
  logic [TX_W-1:0]      tx4_r, tx_nxt;
  logic [CHAN_W-1:0]    qv4_r, qm4_r;
  sector_t              sec4_r;
  // stage 5: output register
  logic [8:0]           qx_full;
  logic [CHAN_W-1:0]    qx;
  logic [CHAN_W-1:0]    red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;

  assign hue        = in_tdata[15:0];
  assign saturation = in_tdata[26:16];
  assign brightness = in_tdata[37:27];

  // a stage takes new data when empty or when its successor moves
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_tready     = en[0];
  assign hue_ctrl.adv  = en[2:0];
  assign hue_ctrl.full = vld_r[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // hue sector and fraction, lined up with stage 2
  hsv2rgb_hue_split u_hue (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (hue_ctrl),
    .hue_i  (hue),
    .hs_o   (hs)
  );

  // datapath arithmetic
  always_comb begin
    oms    = ONE_U - (FRAC_BITS + 1)'(s_r);
    a_nxt  = v_r * oms;                       // v - c in units of one^2
    b_nxt  = v_r * s_r;                       // chroma in units of one^2
    px_nxt = bcm2_r * hs.fx;
    vsum   = (VW + CW + 1)'(vcm2_r) + (VW + CW + 1)'(HALF_V);
    msum   = (AW + CW + 1)'(acm2_r) + (AW + CW + 1)'(HALF_M);
    qv_nxt = sat8(64'(vsum >> FRAC_BITS));
    qm_nxt = sat8(64'(msum >> (2 * FRAC_BITS)));
    // x + m numerator: 960 * (v - c) + c * fx, all times cmax, plus half
    ex     = (EW'(acm3_r) << 10) - (EW'(acm3_r) << 6) + EW'(px3_r) + EW'(BIAS_X);
    txw    = ex >> (2 * FRAC_BITS + 6);
    tx_nxt = (txw > EW'(TX_CAP)) ? TX_W'(TX_CAP) : txw[TX_W-1:0];
  end

  assign qx_full = div15(tx4_r);
  assign qx      = qx_full[CHAN_W-1:0];

  // channel order by sector
  always_comb begin
    unique case (sec4_r)
      SEC_RED_YEL: begin red_nxt = qv4_r; green_nxt = qx;    blue_nxt = qm4_r; end
      SEC_YEL_GRN: begin red_nxt = qx;    green_nxt = qv4_r; blue_nxt = qm4_r; end
      SEC_GRN_CYN: begin red_nxt = qm4_r; green_nxt = qv4_r; blue_nxt = qx;    end
      SEC_CYN_BLU: begin red_nxt = qm4_r; green_nxt = qx;    blue_nxt = qv4_r; end
      SEC_BLU_MAG: begin red_nxt = qx;    green_nxt = qm4_r; blue_nxt = qv4_r; end
      default: begin red_nxt = qv4_r; green_nxt = qm4_r; blue_nxt = qx; end
    endcase
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s_r <= clamp_unit(saturation);
      v_r <= clamp_unit(brightness);
    end
    if (en[1]) begin
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      v1_r <= v_r;
    end
    if (en[2]) begin
      acm2_r <= a_r * CMAX;
      bcm2_r <= b_r * CMAX;
      vcm2_r <= v1_r * CMAX;
    end
    if (en[3]) begin
      px3_r  <= px_nxt;
      acm3_r <= acm2_r;
      qv3_r  <= qv_nxt;
      qm3_r  <= qm_nxt;
      sec3_r <= hs.sector;
    end
    if (en[4]) begin
      tx4_r  <= tx_nxt;
      qv4_r  <= qv3_r;
      qm4_r  <= qm3_r;
      sec4_r <= sec3_r;
    end
    if (en[5]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {blue_r, green_r, red_r};

  // back pressure only reaches the input when every stage is occupied
  `ASSERT_IMPL(a_stall_full, clk, rst_n, !in_tready, &vld_r)
  // a word moving out of stage 3 lands in stage 4
  `ASSERT_NEXT(a_adv_keep, clk, rst_n, vld_r[3] && en[4], vld_r[4])
  // the x code fed to the divide stays within 8 bits of quotient
  `ASSERT_IMPL(a_tx_cap, clk, rst_n, vld_r[4], tx4_r <= TX_W'(TX_CAP))

endmodule
